// File: rtl/nac_pkg.sv
package nac_pkg;

    localparam int NUM_STATES_DEF  = 16;
    localparam int NUM_SYMBOLS_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int STATE_W  = 4;
    localparam int SYMBOL_W = 5;
    localparam int VERDICT_W = 2;
    localparam int LIVE_W   = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_TRANS  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_FINAL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BEGIN      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SYMBOL     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_END        = 3'd6;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECT   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_START = 2'd2;

    // Control word that walks down the chain with the partial mask.
    typedef struct packed {
        logic                valid;
        logic                is_begin;
        logic                sym_ok;
        logic [SYMBOL_W-1:0] sym;
    } t_walk;

    // Broadcast writes into every cell.
    typedef struct packed {
        logic                clear;
        logic                add;
        logic                mark_start;
        logic                mark_final;
        logic                load;
        logic [STATE_W-1:0]  from;
        logic [STATE_W-1:0]  to;
        logic [SYMBOL_W-1:0] sym;
    } t_cell_wr;

endpackage

// File: rtl/nac_cell.sv
module nac_cell #(
    parameter int NUM_STATES  = nac_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nac_pkg::NUM_SYMBOLS_DEF,
    parameter int CELL_ID     = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nac_pkg::t_cell_wr     i_wr,
    input  logic                  i_next_active,
    input  nac_pkg::t_walk        i_ctl,
    input  logic [NUM_STATES-1:0] i_mask,
    output nac_pkg::t_walk        o_ctl,
    output logic [NUM_STATES-1:0] o_mask,
    output logic                  o_active,
    output logic                  o_final
);

    localparam int SW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int TW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    logic [NUM_STATES-1:0] r_rows [NUM_SYMBOLS];
    logic                  r_start;
    logic                  r_final;
    logic                  r_active;
    nac_pkg::t_walk        r_ctl;
    logic [NUM_STATES-1:0] r_mask;

    logic                  w_here;
    logic [NUM_STATES-1:0] w_row;
    logic [NUM_STATES-1:0] w_contrib;

    assign w_here = (int'(i_wr.from) == CELL_ID);
    assign w_row  = r_rows[SW'(i_ctl.sym)];

    always_comb begin
        if (i_ctl.is_begin) begin
            // Only the lowest start state gets in: a lower cell already put its bit in.
            w_contrib = (r_start && (i_mask == '0)) ?
                        ({{(NUM_STATES-1){1'b0}}, 1'b1} << CELL_ID) : '0;
        end else begin
            w_contrib = (r_active && i_ctl.sym_ok) ? w_row : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            for (int s = 0; s < NUM_SYMBOLS; s++) begin
                r_rows[s] <= '0;
            end
            r_start  <= 1'b0;
            r_final  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_wr.add && w_here) begin
                r_rows[SW'(i_wr.sym)][TW'(i_wr.to)] <= 1'b1;
            end
            if (i_wr.mark_start && w_here) begin
                r_start <= 1'b1;
            end
            if (i_wr.mark_final && w_here) begin
                r_final <= 1'b1;
            end
            if (i_wr.load) begin
                r_active <= i_next_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= i_mask | w_contrib;
    end

    assign o_ctl    = r_ctl;
    assign o_mask   = r_mask;
    assign o_active = r_active;
    assign o_final  = r_final;

endmodule

// File: rtl/nfa_acceptance_checker.sv
// Checks symbol strings against a loaded nondeterministic automaton.
// Input words arrive on the slave stream: tuser carries the command, tdata
// carries the state and symbol operands. Clear, add transition, mark start,
// mark final and end act on the word as it is accepted. Begin and symbol
// send a token down a row of NUM_STATES cells, one cell per automaton state,
// one cell a cycle; each cell ORs in its contribution and the finished mask
// is loaded back as the new active set, and no further word is taken until
// that load. End places a verdict and the live state mask in the output
// register as it is accepted. While that result waits, words other than end
// are still taken; an end word waits until the output register is free or
// is being emptied in the same cycle.
// Reset (synchronous, active low) empties the automaton, the start and final
// marks and the active set, and drops any pending result. The clear command
// does the same to the automaton state.
module nfa_acceptance_checker #(
    parameter int NUM_STATES  = nac_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nac_pkg::NUM_SYMBOLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // from_state[3:0], symbol_index[8:4], to_state[12:9], zeros
    input  logic [2:0]  i_s_tuser,  // command[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // verdict[1:0], live_states[17:2], zeros
);

    logic [nac_pkg::CMD_W-1:0]    w_cmd;
    logic [nac_pkg::STATE_W-1:0]  w_from;
    logic [nac_pkg::SYMBOL_W-1:0] w_sym;
    logic [nac_pkg::STATE_W-1:0]  w_to;
    logic                         w_is_end;
    logic                         w_acc;
    logic                         w_sym_ok;
    logic                         w_to_ok;

    nac_pkg::t_cell_wr            w_wr;
    nac_pkg::t_walk               w_ctl  [NUM_STATES+1];
    logic [NUM_STATES-1:0]        w_mask [NUM_STATES+1];
    logic [NUM_STATES-1:0]        w_active;
    logic [NUM_STATES-1:0]        w_final;
    logic [NUM_STATES-1:0]        w_tok_v;

    logic                         r_busy;
    logic                         r_have_start;
    logic                         r_out_valid;
    logic [nac_pkg::VERDICT_W-1:0] r_verdict;
    logic [nac_pkg::LIVE_W-1:0]   r_live;
    logic [nac_pkg::VERDICT_W-1:0] n_verdict;

    assign w_cmd  = i_s_tuser;
    assign w_from = i_s_tdata[3:0];
    assign w_sym  = i_s_tdata[8:4];
    assign w_to   = i_s_tdata[12:9];

    assign w_is_end   = (w_cmd == nac_pkg::CMD_END);
    assign o_s_tready = !r_busy && (!r_out_valid || i_m_tready || !w_is_end);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_sym_ok   = (int'(w_sym) < NUM_SYMBOLS);
    assign w_to_ok    = (int'(w_to) < NUM_STATES);

    always_comb begin
        w_wr          = '0;
        w_wr.from     = w_from;
        w_wr.to       = w_to;
        w_wr.sym      = w_sym;
        w_wr.load     = w_ctl[NUM_STATES].valid;
        w_ctl[0]      = '0;
        w_ctl[0].sym  = w_sym;
        w_ctl[0].sym_ok = w_sym_ok;
        case (w_cmd)
            nac_pkg::CMD_CLEAR:      w_wr.clear      = w_acc;
            nac_pkg::CMD_ADD_TRANS:  w_wr.add        = w_acc && w_sym_ok && w_to_ok;
            nac_pkg::CMD_MARK_START: w_wr.mark_start = w_acc;
            nac_pkg::CMD_MARK_FINAL: w_wr.mark_final = w_acc;
            nac_pkg::CMD_BEGIN: begin
                w_ctl[0].valid    = w_acc;
                w_ctl[0].is_begin = 1'b1;
            end
            nac_pkg::CMD_SYMBOL:     w_ctl[0].valid  = w_acc;
            default:                 w_wr.clear      = 1'b0;
        endcase
    end

    assign w_mask[0] = '0;

    for (genvar k = 0; k < NUM_STATES; k++) begin : g_cell
        nac_cell #(
            .NUM_STATES  (NUM_STATES),
            .NUM_SYMBOLS (NUM_SYMBOLS),
            .CELL_ID     (k)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr          (w_wr),
            .i_next_active (w_mask[NUM_STATES][k]),
            .i_ctl         (w_ctl[k]),
            .i_mask        (w_mask[k]),
            .o_ctl         (w_ctl[k+1]),
            .o_mask        (w_mask[k+1]),
            .o_active      (w_active[k]),
            .o_final       (w_final[k])
        );
        assign w_tok_v[k] = w_ctl[k+1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_ctl[0].valid) begin
            r_busy <= 1'b1;
        end else if (w_ctl[NUM_STATES].valid) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_wr.clear) begin
            r_have_start <= 1'b0;
        end else if (w_ctl[NUM_STATES].valid && w_ctl[NUM_STATES].is_begin) begin
            r_have_start <= (w_mask[NUM_STATES] != '0);
        end
    end

    always_comb begin
        if (!r_have_start) begin
            n_verdict = nac_pkg::VERDICT_NO_START;
        end else if ((w_active & w_final) != '0) begin
            n_verdict = nac_pkg::VERDICT_ACCEPT;
        end else begin
            n_verdict = nac_pkg::VERDICT_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && w_is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_is_end) begin
            r_verdict <= n_verdict;
            r_live    <= nac_pkg::LIVE_W'(w_active);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_live, r_verdict};

    // A token leaving the chain always belongs to a walk that is still open.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[NUM_STATES].valid |-> r_busy)
        else $error("token left the chain with no walk open");

    // The chain carries at most one token at a time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("more than one token in the chain");

    // Begin leaves at most one active state.
    a_begin_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[NUM_STATES].valid && w_ctl[NUM_STATES].is_begin) |=> $onehot0(w_active))
        else $error("begin left more than one active state");

    // Without a start state the active set is empty.
    a_no_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_verdict == nac_pkg::VERDICT_NO_START)) |-> (r_live == '0))
        else $error("live states reported without a start state");

endmodule
